@@ design/mlph_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mlph_pkg;

   typedef enum logic [3:0] {
      ST_UNMOUNTED    = 4'd0,
      ST_SUSPENDED    = 4'd1,
      ST_HOLDING      = 4'd2,
      ST_RESETTING    = 4'd3,
      ST_MOUNTING     = 4'd4,
      ST_ACTIVE       = 4'd5,
      ST_AP_FREE      = 4'd6,
      ST_CP_FREE      = 4'd7,
      ST_ACTIVATING   = 4'd8,
      ST_UNMOUNTING   = 4'd9,
      ST_CP_BOOTING   = 4'd10,
      ST_LOCKED_ON    = 4'd11,
      ST_WDOG_TIMEOUT = 4'd12,
      ST_CP_FAIL      = 4'd13,
      ST_AP_FAIL      = 4'd14
   } fsm_state_type;

   localparam logic [3:0] EV_WAKE_HI   = 4'd0;
   localparam logic [3:0] EV_WAKE_LO   = 4'd1;
   localparam logic [3:0] EV_STATUS_HI = 4'd2;
   localparam logic [3:0] EV_STATUS_LO = 4'd3;
   localparam logic [3:0] EV_RESET     = 4'd4;
   localparam logic [3:0] EV_MOUNTED   = 4'd5;
   localparam logic [3:0] EV_UNMOUNTED = 4'd6;
   localparam logic [3:0] EV_SUSPENDED = 4'd7;
   localparam logic [3:0] EV_RESUMED   = 4'd8;
   localparam logic [3:0] EV_ERROR     = 4'd9;
   localparam logic [3:0] EV_HOLD      = 4'd10;
   localparam logic [3:0] EV_TICK      = 4'd11;
   localparam logic [3:0] EV_START     = 4'd12;
   localparam logic [3:0] EV_STOP      = 4'd13;
   localparam logic [3:0] EV_WDOG_FIRE = 4'd14;
   localparam logic [3:0] EV_HOLD_FIRE = 4'd15;

   localparam logic [1:0] MODE_LOCKED  = 2'd1;
   localparam logic [1:0] MODE_BOOTING = 2'd2;

   localparam int unsigned REG_WATCHDOG = 0;
   localparam int unsigned REG_HOLD     = 1;
   localparam logic [15:0] WATCHDOG_RESET = 16'd1000;
   localparam logic [15:0] HOLD_RESET     = 16'd100;
   localparam int unsigned QUEUE_DEPTH    = 2;

   typedef struct packed {
      logic [3:0] kind;
      logic [1:0] start_mode;
      logic       peer_wakeup_level;
      logic       peer_status_level;
      logic       peer_online;
      logic       link_is_suspended;
   } req_word_type;

   typedef struct packed {
      logic [3:0] fsm_state_out;
      logic       wakeup_pin_out;
      logic       status_pin_out;
      logic       sys_lock_out;
      logic       suspend_block_out;
      logic       reload_pulse;
      logic       pm_fail_pulse;
      logic       cp_fail_pulse;
      logic       link_up;
      logic       running;
   } rsp_word_type;

   // classified command handed from front to back
   typedef struct packed {
      logic         is_fsm;
      logic         is_tick;
      logic         is_start;
      logic         is_stop;
      req_word_type word;
   } cmd_type;

   typedef struct packed {
      fsm_state_type state;
      logic          running;
      logic          hold_pending;
      logic          wakeup_pin;
      logic          status_pin;
      logic          sys_lock;
      logic          suspend_block;
      logic          wdog_armed;
      fsm_state_type wdog_owner;
      fsm_state_type wdog_wait;
      logic          hold_armed;
      logic          reload;
      logic          pm_fail;
      logic          cp_fail;
   } ctx_type;

   function automatic ctx_type wdog_start(ctx_type c, fsm_state_type owner,
                                          fsm_state_type waitst);
      ctx_type r;
      r = c;
      r.wdog_owner = owner;
      r.wdog_wait  = waitst;
      r.wdog_armed = 1'b1;
      return r;
   endfunction

   function automatic ctx_type run_fsm(ctx_type ci, logic [3:0] ev, logic lv_wake,
                                       logic lv_status, logic lv_online,
                                       logic lv_susp, output logic wdog_load,
                                       output logic hold_load);
      ctx_type       c;
      fsm_state_type cs;
      fsm_state_type n;
      logic          skip;
      c         = ci;
      cs        = ci.state;
      n         = cs;
      skip      = 1'b0;
      wdog_load = 1'b0;
      hold_load = 1'b0;
      if (!c.running) begin
         c.wakeup_pin = 1'b0;
         if (ev == EV_ERROR && cs != ST_CP_FAIL) begin
            c.cp_fail = 1'b1;
         end
         return c;
      end
      if (cs == ST_LOCKED_ON || cs == ST_WDOG_TIMEOUT || cs == ST_CP_FAIL) begin
         skip = 1'b1;
      end else if (ev == EV_HOLD) begin
         if (!lv_online) begin
            skip = 1'b1;
         end else begin
            c.hold_pending = 1'b1;
            if (!(cs == ST_UNMOUNTED || cs == ST_AP_FREE || cs == ST_CP_FREE)) begin
               skip = 1'b1;
            end
         end
      end
      if (skip) begin
         return c;
      end
      unique case (cs)
         ST_UNMOUNTED, ST_SUSPENDED: begin
            if (cs == ST_UNMOUNTED && ev == EV_SUSPENDED) begin
               n = ST_SUSPENDED;
            end else if ((ev == EV_WAKE_HI || ev == EV_HOLD) &&
                         (cs == ST_SUSPENDED || lv_susp)) begin
               n = ST_SUSPENDED;
               c.sys_lock = 1'b1;
               c.suspend_block = 1'b1;
            end else if ((cs == ST_UNMOUNTED && (ev == EV_WAKE_HI || ev == EV_HOLD)) ||
                         (cs == ST_SUSPENDED && ev == EV_RESUMED)) begin
               if (lv_wake) begin
                  c.hold_pending = 1'b0;
                  c.sys_lock = 1'b1;
                  c.suspend_block = 1'b1;
                  c.reload = 1'b1;
                  c.wakeup_pin = 1'b1;
                  c = wdog_start(c, ST_RESETTING, ST_MOUNTING);
                  wdog_load = 1'b1;
                  n = ST_RESETTING;
               end else if (c.hold_pending) begin
                  c.hold_pending = 1'b0;
                  c.sys_lock = 1'b1;
                  c.suspend_block = 1'b1;
                  c.wakeup_pin = 1'b1;
                  c = wdog_start(c, ST_HOLDING, ST_RESETTING);
                  wdog_load = 1'b1;
                  n = ST_HOLDING;
               end else begin
                  n = ST_UNMOUNTED;
               end
            end
         end
         ST_HOLDING: begin
            if (ev == EV_WAKE_HI || (ev == EV_WDOG_FIRE && lv_wake)) begin
               n = ST_RESETTING;
               c.reload = 1'b1;
               c = wdog_start(c, ST_RESETTING, ST_MOUNTING);
               wdog_load = 1'b1;
            end else if (ev == EV_WDOG_FIRE) begin
               n = ST_WDOG_TIMEOUT;
            end
         end
         ST_RESETTING: begin
            if (ev == EV_RESET) begin
               n = ST_MOUNTING;
               c.status_pin = 1'b1;
               c = wdog_start(c, ST_MOUNTING, ST_ACTIVE);
               wdog_load = 1'b1;
            end else if (ev == EV_WDOG_FIRE) begin
               n = ST_AP_FAIL;
            end else if (ev == EV_WAKE_LO) begin
               n = ST_CP_FAIL;
            end
         end
         ST_MOUNTING: begin
            if (ev == EV_MOUNTED || ev == EV_STATUS_HI) begin
               n = ST_ACTIVE;
               if (c.wdog_owner == ST_MOUNTING) c.wdog_armed = 1'b0;
            end else if (ev == EV_WDOG_FIRE) begin
               n = ST_WDOG_TIMEOUT;
            end else if (ev == EV_WAKE_LO) begin
               n = ST_AP_FAIL;
            end
         end
         ST_ACTIVE: begin
            if (ev == EV_WAKE_LO || ev == EV_STATUS_LO) begin
               n = ST_AP_FREE;
               if (!c.hold_armed) begin
                  c.hold_armed = 1'b1;
                  hold_load = 1'b1;
               end
            end
         end
         ST_AP_FREE: begin
            if (ev == EV_WAKE_HI) begin
               n = ST_ACTIVE;
               c.hold_armed = 1'b0;
               c.wakeup_pin = 1'b1;
            end else if (ev == EV_HOLD) begin
               c.wakeup_pin = 1'b1;
               c.hold_armed = 1'b1;
               hold_load = 1'b1;
            end else if (ev == EV_HOLD_FIRE) begin
               if (!lv_wake) begin
                  n = ST_CP_FREE;
                  c.hold_pending = 1'b0;
                  c.wakeup_pin = 1'b0;
               end else begin
                  n = ST_ACTIVE;
                  c.hold_armed = 1'b0;
                  c.wakeup_pin = 1'b1;
               end
            end else if (ev == EV_STATUS_LO) begin
               n = ST_CP_FAIL;
            end
         end
         ST_CP_FREE: begin
            if (ev == EV_STATUS_LO) begin
               n = ST_UNMOUNTING;
               c = wdog_start(c, ST_UNMOUNTING, ST_UNMOUNTED);
               wdog_load = 1'b1;
            end else if (ev == EV_WAKE_HI) begin
               n = ST_ACTIVE;
               c.wakeup_pin = 1'b1;
            end else if (ev == EV_HOLD) begin
               n = ST_ACTIVATING;
               c.wakeup_pin = 1'b1;
               c = wdog_start(c, ST_ACTIVATING, ST_ACTIVE);
               wdog_load = 1'b1;
            end
         end
         ST_ACTIVATING: begin
            if (ev == EV_WAKE_HI) begin
               n = ST_ACTIVE;
               if (c.wdog_owner == ST_ACTIVATING) c.wdog_armed = 1'b0;
               c.wakeup_pin = 1'b1;
            end else if (ev == EV_STATUS_LO) begin
               n = ST_UNMOUNTING;
               if (c.wdog_owner == ST_ACTIVATING) c.wdog_armed = 1'b0;
               c.wakeup_pin = 1'b0;
            end else if (ev == EV_WDOG_FIRE) begin
               if (lv_wake) n = ST_ACTIVE;
               else if (!lv_status) n = ST_UNMOUNTING;
               else n = ST_WDOG_TIMEOUT;
            end
         end
         ST_UNMOUNTING: begin
            if (ev == EV_UNMOUNTED) begin
               n = ST_UNMOUNTED;
               if (c.hold_pending) begin
                  if (lv_online) n = ST_HOLDING;
                  c.hold_pending = 1'b0;
               end
               if (c.wdog_owner == ST_UNMOUNTING) c.wdog_armed = 1'b0;
               c.status_pin = 1'b0;
               if (n == ST_HOLDING) begin
                  c.sys_lock = 1'b1;
                  c.suspend_block = 1'b1;
                  c.wakeup_pin = 1'b1;
                  c = wdog_start(c, ST_HOLDING, ST_RESETTING);
                  wdog_load = 1'b1;
               end
            end else if (ev == EV_WDOG_FIRE) begin
               n = ST_WDOG_TIMEOUT;
            end
         end
         ST_CP_BOOTING: begin
            if (ev == EV_WAKE_HI) begin
               n = ST_ACTIVE;
               c.wakeup_pin = 1'b1;
            end else if (ev == EV_ERROR) begin
               n = ST_CP_FAIL;
            end
         end
         default: begin
         end
      endcase
      c.state = n;
      if (n != cs) begin
         if (n == ST_UNMOUNTED) c.sys_lock = 1'b0;
         else if (n == ST_ACTIVE) c.sys_lock = 1'b1;
         if (n == ST_WDOG_TIMEOUT) begin
            if (lv_status) c.pm_fail = 1'b1;
            else c.cp_fail = 1'b1;
         end else if (n == ST_CP_FAIL || n == ST_AP_FAIL) begin
            c.cp_fail = 1'b1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ design/modem_link_power_handshake_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Link power handshake controller. Event words enter a two-entry queue and are
// executed one per cycle, back to back while rsp_ready is high, by the back end,
// which holds the handshake state, pins, locks and the watchdog and hold timers;
// each word yields one result word, registered as the word leaves the queue.
// Timer registers sit at byte addresses 0 (watchdog) and 4 (hold); zero acts as one.
module modem_link_power_handshake_fsm #(
   parameter int unsigned QUEUE_DEPTH = mlph_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire mlph_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output mlph_pkg::rsp_word_type rsp_word,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire  [2:0]             csr_paddr,
   input  wire  [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   logic              cmd_valid, cmd_ready;
   mlph_pkg::cmd_type cmd;
   logic [15:0]       wd_ff, hd_ff;
   logic              wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         1'b0:    csr_prdata = {16'd0, wd_ff};
         default: csr_prdata = {16'd0, hd_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_ff <= mlph_pkg::WATCHDOG_RESET;
         hd_ff <= mlph_pkg::HOLD_RESET;
      end else if (wr) begin
         if (csr_paddr[2] == 1'(mlph_pkg::REG_WATCHDOG)) wd_ff <= csr_pwdata[15:0];
         if (csr_paddr[2] == 1'(mlph_pkg::REG_HOLD)) hd_ff <= csr_pwdata[15:0];
      end
   end

   mlph_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .cmd_valid, .cmd_ready, .cmd
   );

   mlph_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .watchdog_ticks(wd_ff), .hold_ticks(hd_ff),
      .rsp_valid, .rsp_ready, .rsp_word
   );
endmodule
`default_nettype wire

@@ design/mlph_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mlph_front #(
   parameter int unsigned DEPTH = mlph_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire mlph_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  wire                   cmd_ready,
   output mlph_pkg::cmd_type     cmd
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mlph_pkg::cmd_type    q_ff [DEPTH];
   mlph_pkg::cmd_type    cls;
   logic [AW-1:0]        wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]          cnt_ff, cnt_in;
   logic                 push, pop;

   always_comb begin
      cls          = '0;
      cls.word     = req_word;
      cls.is_fsm   = req_word.kind <= mlph_pkg::EV_HOLD;
      cls.is_tick  = req_word.kind == mlph_pkg::EV_TICK;
      cls.is_start = req_word.kind == mlph_pkg::EV_START;
      cls.is_stop  = req_word.kind == mlph_pkg::EV_STOP;
   end

   assign req_ready = cnt_ff != (AW+1)'(DEPTH);
   assign cmd_valid = cnt_ff != '0;
   assign cmd       = q_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      if (pop) rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= cls;
   end
endmodule
`default_nettype wire

@@ design/mlph_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mlph_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_valid,
   output logic                  cmd_ready,
   input  wire mlph_pkg::cmd_type cmd,
   input  wire [15:0]            watchdog_ticks,
   input  wire [15:0]            hold_ticks,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output mlph_pkg::rsp_word_type rsp_word
);
   mlph_pkg::ctx_type      ctx_ff, ctx_in, a, b, t;
   logic [15:0]            wcnt_ff, wcnt_in, hcnt_ff, hcnt_in;
   logic [15:0]            wreload, hreload;
   logic                   wl_a, hl_a, wl_b, hl_b;
   logic                   wfire, hfire;
   logic                   rv_ff, rv_in, take;
   mlph_pkg::rsp_word_type rsp_ff, rsp_in;
   mlph_pkg::req_word_type w;

   assign wreload   = (watchdog_ticks == '0) ? 16'd1 : watchdog_ticks;
   assign hreload   = (hold_ticks == '0) ? 16'd1 : hold_ticks;
   assign cmd_ready = !rv_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign w         = cmd.word;
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      t = ctx_ff;
      t.reload  = 1'b0;
      t.pm_fail = 1'b0;
      t.cp_fail = 1'b0;
      wcnt_in = wcnt_ff;
      hcnt_in = hcnt_ff;
      wfire = t.wdog_armed && wcnt_ff <= 16'd1;
      a = t;
      wl_a = 1'b0;
      hl_a = 1'b0;
      b = t;
      wl_b = 1'b0;
      hl_b = 1'b0;
      hfire = 1'b0;
      ctx_in = t;
      priority if (cmd.is_fsm) begin
         ctx_in = mlph_pkg::run_fsm(t, w.kind, w.peer_wakeup_level, w.peer_status_level,
            w.peer_online, w.link_is_suspended, wl_a, hl_a);
         if (wl_a) wcnt_in = wreload;
         if (hl_a) hcnt_in = hreload;
      end else if (cmd.is_tick) begin
         // watchdog first, then hold timer
         if (t.wdog_armed) begin
            if (wfire) begin
               a.wdog_armed = 1'b0;
               wcnt_in = '0;
               if (a.wdog_wait != a.state) begin
                  a = mlph_pkg::run_fsm(a, mlph_pkg::EV_WDOG_FIRE, w.peer_wakeup_level,
                     w.peer_status_level, w.peer_online, w.link_is_suspended,
                     wl_a, hl_a);
                  if (wl_a) wcnt_in = wreload;
               end
            end else begin
               wcnt_in = wcnt_ff - 1'b1;
            end
         end
         b = a;
         if (a.hold_armed) begin
            if (hl_a) begin
               hcnt_in = hreload;
               if (hreload <= 16'd1) hfire = 1'b1;
               else hcnt_in = hreload - 1'b1;
            end else if (hcnt_ff <= 16'd1) begin
               hfire = 1'b1;
            end else begin
               hcnt_in = hcnt_ff - 1'b1;
            end
            if (hfire) begin
               b.hold_armed = 1'b0;
               hcnt_in = '0;
               b = mlph_pkg::run_fsm(b, mlph_pkg::EV_HOLD_FIRE, w.peer_wakeup_level,
                  w.peer_status_level, w.peer_online, w.link_is_suspended, wl_b, hl_b);
               if (wl_b) wcnt_in = wreload;
               if (hl_b) hcnt_in = hreload;
            end
         end
         ctx_in = b;
      end else if (cmd.is_start) begin
         if (!t.running) begin
            ctx_in.sys_lock = 1'b1;
            if (w.start_mode == mlph_pkg::MODE_LOCKED ||
                w.start_mode == mlph_pkg::MODE_BOOTING) begin
               ctx_in.state = (w.start_mode == mlph_pkg::MODE_LOCKED) ?
                  mlph_pkg::ST_LOCKED_ON : mlph_pkg::ST_CP_BOOTING;
               ctx_in.wakeup_pin = 1'b1;
               ctx_in.status_pin = 1'b1;
            end else begin
               ctx_in.state = mlph_pkg::ST_UNMOUNTED;
               ctx_in.wakeup_pin = 1'b0;
               ctx_in.status_pin = 1'b0;
            end
            ctx_in.hold_pending = 1'b0;
            ctx_in.running = 1'b1;
         end
      end else if (cmd.is_stop) begin
         if (t.running) begin
            ctx_in.running = 1'b0;
            ctx_in.state = mlph_pkg::ST_UNMOUNTED;
         end
      end else begin
         ctx_in = t;
      end
   end

   always_comb begin
      rsp_in.fsm_state_out     = ctx_in.state;
      rsp_in.wakeup_pin_out    = ctx_in.wakeup_pin;
      rsp_in.status_pin_out    = ctx_in.status_pin;
      rsp_in.sys_lock_out      = ctx_in.sys_lock;
      rsp_in.suspend_block_out = ctx_in.suspend_block;
      rsp_in.reload_pulse      = ctx_in.reload;
      rsp_in.pm_fail_pulse     = ctx_in.pm_fail;
      rsp_in.cp_fail_pulse     = ctx_in.cp_fail;
      rsp_in.link_up           = ctx_in.state == mlph_pkg::ST_LOCKED_ON ||
                                 ctx_in.state == mlph_pkg::ST_ACTIVE ||
                                 ctx_in.state == mlph_pkg::ST_AP_FREE;
      rsp_in.running           = ctx_in.running;
      rv_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '{state: mlph_pkg::ST_UNMOUNTED, wdog_owner: mlph_pkg::ST_UNMOUNTED,
                     wdog_wait: mlph_pkg::ST_UNMOUNTED, default: 1'b0};
         wcnt_ff <= '0;
         hcnt_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         if (take) begin
            ctx_ff  <= ctx_in;
            wcnt_ff <= wcnt_in;
            hcnt_ff <= hcnt_in;
         end
         rv_ff <= rv_in;
      end
      if (take) rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire
